FILE: hdl/scpa_pkg.sv
// Package for the size class pool allocator: constants, types and helpers.
// Used by every module of the block; depends on nothing.
package scpa_pkg;

  localparam int HeapBytes       = 262144;
  localparam int PoolBytes       = 4096;
  localparam int GrainBytes      = 8;
  localparam int SmallLimit      = 512;
  localparam int MaxHeaps        = 16;
  localparam int PoolHeaderBytes = 24;

  localparam int PoolsPerHeap = (HeapBytes / PoolBytes) > 0 ? (HeapBytes / PoolBytes) : 1;
  localparam int PoolCount    = MaxHeaps * PoolsPerHeap;
  localparam int NumClasses   = (SmallLimit + GrainBytes - 1) / GrainBytes;
  localparam int LinkDepth    = 4194304 / GrainBytes;

  localparam int AddrW  = 22;
  localparam int ClassW = 6;
  localparam int PoolW  = $clog2(PoolCount);
  localparam int SlotW  = $clog2(PoolsPerHeap + 1);
  localparam int OffW   = $clog2(PoolBytes + 1) + 1;
  localparam int HeapW  = $clog2(MaxHeaps + 1);
  localparam int LinkW  = $clog2(LinkDepth);
  localparam int GrainSh = $clog2(GrainBytes);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    StAlloc  = 2'd0,
    StFreed  = 2'd1,
    StSystem = 2'd2,
    StOom    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SrcReuse = 2'd0,
    SrcCarve = 2'd1,
    SrcPool  = 2'd2,
    SrcHeap  = 2'd3
  } source_e;

  typedef enum logic [1:0] {
    OpAlloc  = 2'd0,
    OpFree   = 2'd1,
    OpSystem = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BkIdle = 2'd0,
    BkRead = 2'd1,
    BkLink = 2'd2,
    BkExec = 2'd3
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [ClassW-1:0] cls;
    logic [AddrW-1:0]  addr;
    logic [PoolW-1:0]  pool;
  } cmd_t;

  function automatic logic [AddrW-1:0] pool_base(input logic [PoolW-1:0] id);
    logic [31:0] b;
    b = (32'(id) / PoolsPerHeap) * HeapBytes + (32'(id) % PoolsPerHeap) * PoolBytes;
    return b[AddrW-1:0];
  endfunction

endpackage

FILE: hdl/scpa_front.sv
// Front end: takes requests, classifies them and queues commands.
// Depends on scpa_pkg.
module scpa_front import scpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              action_i,
  input  logic [31:0]       request_size_i,
  input  logic [AddrW-1:0]  block_address_i,
  input  logic [HeapW-1:0]  heaps_opened_i,
  input  logic              pop_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  output logic              empty_o
);

  cmd_t                     q_mem_q [QDepth];
  logic [$clog2(QDepth):0]  cnt_q, cnt_d;
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  cmd_t                     c;
  logic                     push;
  logic [31:0]              h, rel, slot, sz;

  always_comb begin
    c = '0;
    h = 32'(block_address_i) / HeapBytes;
    rel = 32'(block_address_i) % HeapBytes;
    slot = rel / PoolBytes;
    sz = request_size_i + 32'(GrainBytes - 1);
    if (action_i) begin
      if (h >= 32'(heaps_opened_i) || rel == 0) begin
        c.op = OpSystem;
      end else begin
        c.op = OpFree;
        c.addr = block_address_i;
        c.pool = PoolW'(h * PoolsPerHeap + slot);
      end
    end else if (request_size_i > 32'(SmallLimit)) begin
      c.op = OpSystem;
    end else begin
      c.op = OpAlloc;
      if (request_size_i == 0) c.cls = '0;
      else c.cls = ClassW'((sz >> GrainSh) - 32'd1);
    end
  end

  // Heaps opened can change while a command waits, so one request is in flight.
  assign busy = cnt_q != 0;
  assign push = start && !busy;
  assign cmd_valid_o = cnt_q != 0;
  assign cmd_o = q_mem_q[rp_q];
  assign empty_o = cnt_q == 0;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i && cnt_q != 0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= wp_q + 1'b1;
      if (pop_i && cnt_q != 0) rp_q <= rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= c;
  end

endmodule

FILE: hdl/scpa_back.sv
// Back end: free lists, pool and heap bookkeeping, link and class memories.
// Depends on scpa_pkg.
module scpa_back import scpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  input  logic [4:0]        heap_limit_i,
  output logic [HeapW-1:0]  heaps_opened_o,
  output logic              res_valid_o,
  output logic [1:0]        status_o,
  output logic [AddrW-1:0]  granted_address_o,
  output logic [1:0]        source_o,
  output logic [ClassW-1:0] size_class_o
);

  logic [AddrW:0]      link_mem [LinkDepth];
  logic [ClassW-1:0]   class_mem [PoolCount];
  logic [AddrW-1:0]    fh_addr_mem [NumClasses];
  logic [PoolW-1:0]    op_index_mem [NumClasses];
  logic [OffW-1:0]     op_off_mem [NumClasses];
  logic [AddrW:0]      link_rd_q;
  logic [ClassW-1:0]   class_rd_q;
  logic [AddrW-1:0]    fh_rd_q;
  logic [PoolW-1:0]    idx_rd_q;
  logic [OffW-1:0]     off_rd_q;

  logic [NumClasses-1:0] fh_valid_q, op_valid_q;
  logic [HeapW-1:0]    heaps_q;
  logic                oh_valid_q;
  logic [SlotW-1:0]    oh_next_q;

  back_state_e st_q, st_d;
  cmd_t        cmd_q;

  logic [ClassW-1:0] c;
  logic [OffW-1:0]   blk, off, noff;
  logic [PoolW-1:0]  nid;
  logic [HeapW-1:0]  lim;
  logic              do_exec, can_new, do_free, do_reuse, do_carve, do_new;

  assign heaps_opened_o = heaps_q;
  assign c = (cmd_q.op == OpFree) ? class_rd_q : cmd_q.cls;
  assign blk = OffW'((32'(c) + 1) * GrainBytes);
  assign off = off_rd_q;
  assign lim = (32'(heap_limit_i) < MaxHeaps) ? HeapW'(heap_limit_i) : HeapW'(MaxHeaps);
  assign nid = oh_valid_q && heaps_q != 0 ?
               PoolW'(32'(heaps_q - HeapW'(1)) * PoolsPerHeap + 32'(oh_next_q)) :
               PoolW'(32'(heaps_q) * PoolsPerHeap);
  assign noff = OffW'(PoolHeaderBytes) + blk;
  assign can_new = (oh_valid_q && heaps_q != 0) || heaps_q < lim;
  assign do_free = do_exec && cmd_q.op == OpFree;
  assign do_reuse = do_exec && cmd_q.op == OpAlloc && fh_valid_q[c];
  assign do_carve = do_exec && cmd_q.op == OpAlloc && !fh_valid_q[c] && op_valid_q[c];
  assign do_new = do_exec && cmd_q.op == OpAlloc && !fh_valid_q[c] && !op_valid_q[c] &&
                  can_new;

  always_comb begin
    st_d = st_q;
    pop_o = 1'b0;
    do_exec = 1'b0;
    unique case (st_q)
      BkIdle: if (cmd_valid_i) begin
        pop_o = 1'b1;
        st_d = BkRead;
      end
      BkRead: st_d = BkLink;
      BkLink: st_d = BkExec;
      BkExec: begin
        do_exec = 1'b1;
        st_d = BkIdle;
      end
      default: st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (st_q == BkRead) begin
      class_rd_q <= class_mem[cmd_q.pool];
      fh_rd_q <= fh_addr_mem[cmd_q.cls];
    end
    if (st_q == BkLink) begin
      link_rd_q <= link_mem[LinkW'(fh_rd_q >> GrainSh)];
      fh_rd_q <= fh_addr_mem[c];
      idx_rd_q <= op_index_mem[c];
      off_rd_q <= op_off_mem[c];
    end
    if (do_free) begin
      link_mem[LinkW'(cmd_q.addr >> GrainSh)] <= {fh_valid_q[c], fh_rd_q};
      fh_addr_mem[c] <= cmd_q.addr;
    end
    if (do_reuse) fh_addr_mem[c] <= link_rd_q[AddrW-1:0];
    if (do_carve) op_off_mem[c] <= off + blk;
    if (do_new) begin
      class_mem[nid] <= c;
      op_index_mem[c] <= nid;
      op_off_mem[c] <= noff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      fh_valid_q <= '0;
      op_valid_q <= '0;
      heaps_q <= '0;
      oh_valid_q <= 1'b0;
      oh_next_q <= '0;
      res_valid_o <= 1'b0;
      status_o <= '0;
      granted_address_o <= '0;
      source_o <= '0;
      size_class_o <= '0;
    end else begin
      st_q <= st_d;
      res_valid_o <= do_exec;
      if (do_exec) begin
        status_o <= StSystem;
        granted_address_o <= '0;
        source_o <= SrcReuse;
        size_class_o <= '0;
        unique case (cmd_q.op)
          OpFree: begin
            fh_valid_q[c] <= 1'b1;
            status_o <= StFreed;
            size_class_o <= c;
          end
          OpAlloc: begin
            size_class_o <= c;
            status_o <= StAlloc;
            if (fh_valid_q[c]) begin
              fh_valid_q[c] <= link_rd_q[AddrW];
              granted_address_o <= fh_rd_q;
            end else if (op_valid_q[c]) begin
              granted_address_o <= pool_base(idx_rd_q) + AddrW'(off);
              if (32'(off) + 2 * 32'(blk) > PoolBytes) op_valid_q[c] <= 1'b0;
              source_o <= SrcCarve;
            end else if (can_new) begin
              if (oh_valid_q && heaps_q != 0) begin
                source_o <= SrcPool;
                oh_next_q <= oh_next_q + SlotW'(1);
                if (32'(oh_next_q) + 1 >= PoolsPerHeap) oh_valid_q <= 1'b0;
              end else begin
                source_o <= SrcHeap;
                heaps_q <= heaps_q + HeapW'(1);
                oh_next_q <= SlotW'(1);
                oh_valid_q <= PoolsPerHeap > 1;
              end
              op_valid_q[c] <= 32'(noff) + 32'(blk) <= PoolBytes;
              granted_address_o <= pool_base(nid) + AddrW'(PoolHeaderBytes);
            end else begin
              status_o <= StOom;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/size_class_pool_allocator.sv
// Top level of the size class pool allocator: front end, command queue, back end.
// Depends on scpa_pkg, scpa_front and scpa_back.
//
//   channel   handshake          payload
//   request   start / busy       action_i, request_size_i, block_address_i
//   result    done_o strobe      status_o, granted_address_o, source_o, size_class_o
//   config    heap_limit_we_i    heap_limit_i
//
// done_o rises once a taken request has moved as a command into the back end and passed
// its two memory read states (BkRead, BkLink) and its update state (BkExec).
// busy holds through the done_o cycle, so a new request is taken only after that result.
// Reset clears all control state and sets heap_limit to 16.
// The receiver cannot stall; each result is shown for one cycle.
module size_class_pool_allocator import scpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              action_i,
  input  logic [31:0]       request_size_i,
  input  logic [AddrW-1:0]  block_address_i,
  input  logic              heap_limit_we_i,
  input  logic [4:0]        heap_limit_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [AddrW-1:0]  granted_address_o,
  output logic [1:0]        source_o,
  output logic [ClassW-1:0] size_class_o
);

  logic [4:0]       limit_q;
  logic             fbusy, pop, cv, empty, inflight_q;
  cmd_t             cmd;
  logic [HeapW-1:0] heaps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 5'd16;
      inflight_q <= 1'b0;
    end else begin
      if (heap_limit_we_i) limit_q <= heap_limit_i;
      if (start && !busy) inflight_q <= 1'b1;
      else if (done_o) inflight_q <= 1'b0;
    end
  end

  assign busy = fbusy || inflight_q;

  scpa_front u_front (
    .clk_i, .rst_ni,
    .start(start && !inflight_q),
    .busy(fbusy),
    .action_i, .request_size_i, .block_address_i,
    .heaps_opened_i(heaps),
    .pop_i(pop),
    .cmd_valid_o(cv),
    .cmd_o(cmd),
    .empty_o(empty)
  );

  scpa_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cv && !empty),
    .cmd_i(cmd),
    .pop_o(pop),
    .heap_limit_i(limit_q),
    .heaps_opened_o(heaps),
    .res_valid_o(done_o),
    .status_o, .granted_address_o, .source_o, .size_class_o
  );

endmodule
